>>> hdl/qcs_pkg.sv
// Shared types and constants for the Q-criterion stencil.
`default_nettype none
package qcs_pkg;

    localparam int MAX_X_DEF     = 64;
    localparam int MAX_Y_DEF     = 64;
    localparam int FRAC_BITS_DEF = 12;
    localparam int MAX_Z         = 4096;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X    = 2'd0,
        REG_SIZE_Y    = 2'd1,
        REG_SIZE_Z    = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SEND
    } seq_state_t;

    // Fetch slots: memory reads issued one per cycle for one item.
    typedef enum logic [2:0] {
        RD_CTR,
        RD_VP_X,
        RD_VM_X,
        RD_VP_Y,
        RD_VM_Y,
        RD_VP_Z,
        RD_VM_Z,
        RD_DONE
    } rd_slot_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_MET,
        P_ACC,
        P_QACC,
        P_FIN
    } grad_phase_t;

    localparam int VEL_W    = 48;
    localparam int METRIC_W = 48;
    localparam int Q_W      = 48;

    typedef struct packed {
        logic [47:0] vel;
        logic [47:0] xi;
        logic [47:0] eta;
        logic [47:0] zeta;
        logic [15:0] scale;
        logic [14:0] marker;
    } cell_word_t;

endpackage
`default_nettype wire

>>> hdl/qcs_if.sv
// Valid/ready channel interfaces for cell input, result output and register writes.
`default_nettype none
interface qcs_cell_if;
    logic        valid;
    logic        ready;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] vel_z;
    logic [47:0] xi_metric;
    logic [47:0] eta_metric;
    logic [47:0] zeta_metric;
    logic [15:0] jacobian_scale;
    logic [14:0] solid_marker;
    modport source (output valid, vel_x, vel_y, vel_z, xi_metric, eta_metric, zeta_metric,
                    jacobian_scale, solid_marker, input ready);
    modport sink (input valid, vel_x, vel_y, vel_z, xi_metric, eta_metric, zeta_metric,
                  jacobian_scale, solid_marker, output ready);
endinterface

interface qcs_result_if;
    logic        valid;
    logic        ready;
    logic [47:0] q_value;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [11:0] cell_z;
    logic        last_cell;
    modport source (output valid, q_value, cell_x, cell_y, cell_z, last_cell, input ready);
    modport sink (input valid, q_value, cell_x, cell_y, cell_z, last_cell, output ready);
endinterface

interface qcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/qcs_window.sv
// Ring memory of recent cells: one write port, one registered read port.
`default_nettype none
module qcs_window #(
    parameter int DEPTH = 8193,
    parameter int AW    = 14
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire qcs_pkg::cell_word_t  wr_data,
    input  wire logic [AW-1:0]        rd_addr,
    output qcs_pkg::cell_word_t       rd_data
);
    import qcs_pkg::*;

    cell_word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> hdl/qcs_grad.sv
// Gradient and Q datapath: multiply-accumulate over one product per cycle.
`default_nettype none
module qcs_grad #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [16:0]  du [3][3],
    input  wire logic [47:0]  ma [3],
    input  wire logic [47:0]  mb [3],
    input  wire logic [15:0]  jac,
    output logic              done,
    output logic [47:0]       q
);
    import qcs_pkg::*;

    localparam int GS = 2 * FRAC_BITS + 2;
    localparam logic signed [63:0] GLIM = 64'sd134217727;
    localparam logic signed [63:0] QMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] QMIN = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;

    grad_phase_t         ph_reg;
    grad_phase_t         ph_next;
    logic [3:0]          i_reg;
    logic [3:0]          i_next;
    logic [1:0]          k_reg;
    logic [1:0]          k_next;
    logic signed [33:0]  met_reg [3][3];
    logic signed [63:0]  acc_reg;
    logic signed [27:0]  g_reg [3][3];
    logic signed [63:0]  q2_reg;
    logic [47:0]         q_reg;

    logic [1:0]          r_i;
    logic [1:0]          c_i;
    logic signed [16:0]  msum;
    logic signed [33:0]  mprod;
    logic signed [50:0]  gprod;
    logic signed [63:0]  acc_sum;
    logic signed [63:0]  g_rnd;
    logic signed [63:0]  g_sat;
    logic signed [27:0]  qa;
    logic signed [27:0]  qb;
    logic signed [63:0]  qp;
    logic signed [63:0]  q_rnd;

    always_comb
    begin
        r_i   = (i_reg >= 4'd6) ? 2'd2 : ((i_reg >= 4'd3) ? 2'd1 : 2'd0);
        c_i   = 2'(i_reg - 4'd3 * 4'(r_i));
        msum  = 17'(signed'(ma[r_i][16*c_i +: 16])) + 17'(signed'(mb[r_i][16*c_i +: 16]));
        mprod = 34'(msum * signed'(jac));
        gprod = 51'(signed'(du[k_reg][r_i]) * met_reg[k_reg][c_i]);
        acc_sum = acc_reg + 64'(gprod);
        g_rnd = (acc_sum + (64'sd1 <<< (GS - 1))) >>> GS;
        g_sat = (g_rnd > GLIM) ? GLIM : ((g_rnd < -GLIM) ? -GLIM : g_rnd);
        case (i_reg)
            4'd0:    begin qa = g_reg[0][0]; qb = g_reg[0][0]; end
            4'd1:    begin qa = g_reg[1][1]; qb = g_reg[1][1]; end
            4'd2:    begin qa = g_reg[2][2]; qb = g_reg[2][2]; end
            4'd3:    begin qa = g_reg[0][1]; qb = g_reg[1][0]; end
            4'd4:    begin qa = g_reg[0][2]; qb = g_reg[2][0]; end
            default: begin qa = g_reg[1][2]; qb = g_reg[2][1]; end
        endcase
        qp    = 64'(qa * qb);
        q_rnd = (q2_reg + 64'sd1) >>> 1;
    end

    always_comb
    begin
        ph_next = ph_reg;
        i_next  = i_reg;
        k_next  = k_reg;
        unique case (ph_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    ph_next = P_MET;
                    i_next  = '0;
                end
            end
            P_MET:
            begin
                if (i_reg == 4'd8)
                begin
                    ph_next = P_ACC;
                    i_next  = '0;
                    k_next  = '0;
                end
                else
                begin
                    i_next = i_reg + 4'd1;
                end
            end
            P_ACC:
            begin
                if (k_reg == 2'd2)
                begin
                    k_next = '0;
                    if (i_reg == 4'd8)
                    begin
                        ph_next = P_QACC;
                        i_next  = '0;
                    end
                    else
                    begin
                        i_next = i_reg + 4'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            P_QACC:
            begin
                if (i_reg == 4'd5)
                begin
                    ph_next = P_FIN;
                end
                i_next = i_reg + 4'd1;
            end
            P_FIN:
            begin
                ph_next = P_IDLE;
            end
            default:
            begin
                ph_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= P_IDLE;
            i_reg  <= '0;
            k_reg  <= '0;
        end
        else
        begin
            ph_reg <= ph_next;
            i_reg  <= i_next;
            k_reg  <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ph_reg)
            P_MET:
            begin
                met_reg[r_i][c_i] <= mprod;
                acc_reg <= '0;
            end
            P_ACC:
            begin
                if (k_reg == 2'd2)
                begin
                    g_reg[r_i][c_i] <= 28'(g_sat);
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
                q2_reg <= '0;
            end
            P_QACC:
            begin
                q2_reg <= (i_reg < 4'd3) ? q2_reg - qp : q2_reg - (qp <<< 1);
            end
            P_FIN:
            begin
                q_reg <= (q_rnd > QMAX) ? QMAX[47:0] :
                         ((q_rnd < QMIN) ? QMIN[47:0] : q_rnd[47:0]);
            end
            default:
            begin
            end
        endcase
    end

    assign done = (ph_reg == P_FIN);
    assign q    = q_reg;
endmodule
`default_nettype wire

>>> hdl/q_criterion_stencil.sv
// Top level of the Q-criterion stencil engine.
//
//  channel    dir  handshake     payload
//  grid_cell  in   valid/ready   velocity, metrics, scale, marker
//  result     out  valid/ready   q_value, cell index, last_cell
//  cfg        in   valid/ready   index, data
//
// A boundary cell is stored without leaving the idle state. An interior cell goes
// through acceptance, 7 serial reads through the one read port of the window
// memory, 9 metric, 27 gradient and 6 Q products (one of each kind per cycle)
// plus rounding, and a final load of the output register.
// Window memory needs no clearing pass; reset clears positions and pointer.
// An interior cell waits after its reads while the previous result is unaccepted.
`default_nettype none
module q_criterion_stencil #(
    parameter int MAX_X     = qcs_pkg::MAX_X_DEF,
    parameter int MAX_Y     = qcs_pkg::MAX_Y_DEF,
    parameter int FRAC_BITS = qcs_pkg::FRAC_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    qcs_cell_if.sink    grid_cell,
    qcs_result_if.source result,
    qcs_cfg_if.sink     cfg
);
    import qcs_pkg::*;

    localparam int DEPTH = 2 * MAX_X * MAX_Y + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_X + 1);
    localparam int YW    = $clog2(MAX_Y + 1);

    seq_state_t  state_reg, state_next;
    rd_slot_t    slot_reg;

    logic [6:0]  size_x_reg;
    logic [6:0]  size_y_reg;
    logic [12:0] size_z_reg;
    logic [14:0] thr_reg;

    logic [XW-1:0] px_reg;
    logic [YW-1:0] py_reg;
    logic [11:0]   pz_reg;
    logic [AW-1:0] wp_reg;

    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic [12:0]   nz;
    logic [AW-1:0] plane;

    logic          interior;
    logic          cell_acc;
    logic          cfg_acc;

    cell_word_t    wr_word;
    cell_word_t    rd_word;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] back_d;
    logic [AW:0]   diff;

    logic [AW-1:0] base_reg;
    logic          rd_pend_reg;
    rd_slot_t      rd_slot_reg;

    logic [47:0]   vp_reg [3];
    logic [47:0]   vm_reg [3];
    logic [47:0]   ma_reg [3];
    logic [47:0]   mb_reg [3];
    logic [15:0]   jac_reg;
    logic [14:0]   mark_reg;
    logic [16:0]   du [3][3];

    logic [5:0]    cx_reg;
    logic [5:0]    cy_reg;
    logic [11:0]   cz_reg;
    logic          clast_reg;

    logic [5:0]    ox_reg;
    logic [5:0]    oy_reg;
    logic [11:0]   oz_reg;
    logic          olast_reg;
    logic          ovalid_reg;
    logic [47:0]   oq_reg;

    logic          g_start;
    logic          g_done;
    logic [47:0]   g_q;

    always_comb
    begin
        nx = (size_x_reg < 7'd3) ? XW'(3) : ((32'(size_x_reg) > MAX_X) ? XW'(MAX_X) : XW'(size_x_reg));
        ny = (size_y_reg < 7'd3) ? YW'(3) : ((32'(size_y_reg) > MAX_Y) ? YW'(MAX_Y) : YW'(size_y_reg));
        nz = (size_z_reg < 13'd3) ? 13'd3 : ((size_z_reg > 13'd4096) ? 13'd4096 : size_z_reg);
        plane = AW'(32'(nx) * 32'(ny));
        interior = (pz_reg >= 12'd2) && (px_reg >= XW'(1)) && (px_reg <= nx - XW'(2)) &&
                   (py_reg >= YW'(1)) && (py_reg <= ny - YW'(2));
    end

    assign grid_cell.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg.ready       = (state_reg == ST_IDLE) && !ovalid_reg;
    assign cell_acc        = grid_cell.valid && grid_cell.ready;
    assign cfg_acc         = cfg.valid && cfg.ready;

    always_comb
    begin
        wr_word.vel    = {grid_cell.vel_z, grid_cell.vel_y, grid_cell.vel_x};
        wr_word.xi     = grid_cell.xi_metric;
        wr_word.eta    = grid_cell.eta_metric;
        wr_word.zeta   = grid_cell.zeta_metric;
        wr_word.scale  = grid_cell.jacobian_scale;
        wr_word.marker = grid_cell.solid_marker;
    end

    always_comb
    begin
        unique case (slot_reg)
            RD_CTR:  back_d = plane;
            RD_VP_X: back_d = plane - AW'(1);
            RD_VM_X: back_d = plane + AW'(1);
            RD_VP_Y: back_d = plane - AW'(nx);
            RD_VM_Y: back_d = plane + AW'(nx);
            RD_VP_Z: back_d = '0;
            RD_VM_Z: back_d = AW'(2 * 32'(plane));
            default: back_d = '0;
        endcase
        diff = {1'b0, base_reg} - {1'b0, back_d};
        rd_addr = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];
    end

    qcs_window #(.DEPTH(DEPTH), .AW(AW)) u_window (
        .clk     (clk),
        .wr_en   (cell_acc),
        .wr_addr (wp_reg),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_comb
    begin
        state_next = state_reg;
        g_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (cell_acc && interior) state_next = ST_READ;
            ST_READ: if (slot_reg == RD_DONE && !ovalid_reg)
                     begin
                         state_next = ST_CALC;
                         g_start = 1'b1;
                     end
            ST_CALC: if (g_done) state_next = ST_SEND;
            ST_SEND: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= RD_CTR;
            rd_pend_reg <= 1'b0;
            rd_slot_reg <= RD_CTR;
            size_x_reg  <= 7'd64;
            size_y_reg  <= 7'd64;
            size_z_reg  <= 13'd64;
            thr_reg     <= 15'd409;
            px_reg      <= '0;
            py_reg      <= '0;
            pz_reg      <= '0;
            wp_reg      <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_SIZE_X:    size_x_reg <= cfg.data[6:0];
                    REG_SIZE_Y:    size_y_reg <= cfg.data[6:0];
                    REG_SIZE_Z:    size_z_reg <= cfg.data[12:0];
                    REG_THRESHOLD: thr_reg    <= cfg.data;
                    default:       thr_reg    <= thr_reg;
                endcase
                if (cfg_reg_t'(cfg.index) != REG_THRESHOLD)
                begin
                    px_reg <= '0;
                    py_reg <= '0;
                    pz_reg <= '0;
                end
            end
            if (cell_acc)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (px_reg + XW'(1) >= nx)
                begin
                    px_reg <= '0;
                    if (py_reg + YW'(1) >= ny)
                    begin
                        py_reg <= '0;
                        pz_reg <= (13'(pz_reg) + 13'd1 >= nz) ? '0 : pz_reg + 12'd1;
                    end
                    else
                    begin
                        py_reg <= py_reg + YW'(1);
                    end
                end
                else
                begin
                    px_reg <= px_reg + XW'(1);
                end
                slot_reg <= RD_CTR;
                rd_pend_reg <= 1'b0;
            end
            else if (state_reg == ST_READ && slot_reg != RD_DONE)
            begin
                rd_pend_reg <= 1'b1;
                rd_slot_reg <= slot_reg;
                slot_reg    <= rd_slot_t'(slot_reg + 3'd1);
            end
            else if (state_reg == ST_READ)
            begin
                rd_pend_reg <= 1'b0;
            end
            if (state_reg == ST_SEND)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_acc)
        begin
            base_reg  <= wp_reg;
            cx_reg    <= 6'(px_reg);
            cy_reg    <= 6'(py_reg);
            cz_reg    <= pz_reg - 12'd1;
            clast_reg <= (px_reg == nx - XW'(2)) && (py_reg == ny - YW'(2)) &&
                         (13'(pz_reg) == nz - 13'd1);
        end
        if (state_reg == ST_READ && rd_pend_reg)
        begin
            case (rd_slot_reg)
                RD_CTR:
                begin
                    ma_reg[0] <= rd_word.xi;
                    ma_reg[1] <= rd_word.eta;
                    ma_reg[2] <= rd_word.zeta;
                    jac_reg   <= rd_word.scale;
                    mark_reg  <= rd_word.marker;
                end
                RD_VP_X: vp_reg[0] <= rd_word.vel;
                RD_VM_X:
                begin
                    vm_reg[0] <= rd_word.vel;
                    mb_reg[0] <= rd_word.xi;
                end
                RD_VP_Y: vp_reg[1] <= rd_word.vel;
                RD_VM_Y:
                begin
                    vm_reg[1] <= rd_word.vel;
                    mb_reg[1] <= rd_word.eta;
                end
                RD_VP_Z: vp_reg[2] <= rd_word.vel;
                RD_VM_Z:
                begin
                    vm_reg[2] <= rd_word.vel;
                    mb_reg[2] <= rd_word.zeta;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_SEND)
        begin
            oq_reg    <= (mark_reg > thr_reg) ? '0 : g_q;
            ox_reg    <= cx_reg;
            oy_reg    <= cy_reg;
            oz_reg    <= cz_reg;
            olast_reg <= clast_reg;
        end
    end

    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                du[m][r] = 17'(signed'(vp_reg[m][16*r +: 16])) -
                           17'(signed'(vm_reg[m][16*r +: 16]));
            end
        end
    end

    qcs_grad #(.FRAC_BITS(FRAC_BITS)) u_grad (
        .clk   (clk),
        .rst_n (rst_n),
        .start (g_start),
        .du    (du),
        .ma    (ma_reg),
        .mb    (mb_reg),
        .jac   (jac_reg),
        .done  (g_done),
        .q     (g_q)
    );

    assign result.valid     = ovalid_reg;
    assign result.q_value   = oq_reg;
    assign result.cell_x    = ox_reg;
    assign result.cell_y    = oy_reg;
    assign result.cell_z    = oz_reg;
    assign result.last_cell = olast_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !grid_cell.ready) else $error("cell accepted while busy");
    a_send_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> $past(state_reg) == ST_CALC) else $error("send order");
    a_valid_after_send: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |=> result.valid) else $error("result lost");
`endif
endmodule
`default_nettype wire
